// File: rtl/dstq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the deadline sorted task queue: sizes, codes, payload and control types.
// No dependencies; every other file of the block imports it.

package dstq_pkg;

  // Table sizes and time width.
  localparam int ACTIVE_DEPTH  = 16;
  localparam int OVERDUE_DEPTH = 8;
  localparam int TIME_BITS     = 32;
  localparam int ID_BITS       = 8;

  // Derived widths.
  localparam int IDX_W = $clog2(ACTIVE_DEPTH);
  localparam int CNT_W = $clog2(ACTIVE_DEPTH + 1);
  localparam int OV_W  = $clog2(OVERDUE_DEPTH + 1);

  // Command codes.
  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_CLEANUP = 2'd2,
    CMD_TRIM    = 2'd3
  } cmd_e;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_EMPTY     = 3'd3,
    STAT_DROPPED   = 3'd4
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_UPDATE,
    S_CLEAN,
    S_TRIM,
    S_DONE
  } state_e;

  // Request payload.
  typedef struct packed {
    cmd_e                 cmd;
    logic [ID_BITS-1:0]   task_id;
    logic [TIME_BITS-1:0] deadline;
    logic [TIME_BITS-1:0] now;
  } req_t;

  // Response payload.
  typedef struct packed {
    status_e              status;
    logic [IDX_W-1:0]     position;
    logic [CNT_W-1:0]     active_count;
    logic [OV_W-1:0]      overdue_count;
    logic [CNT_W-1:0]     moved_count;
    logic [ID_BITS-1:0]   head_id;
    logic [TIME_BITS-1:0] head_deadline;
  } rsp_t;

  // Datapath controls produced by the sequencer.
  typedef struct packed {
    logic             ld_req;
    logic             idx_inc;
    logic             set_pos;
    logic             wr_ins;
    logic             wr_del;
    logic             del_head;
    logic             used_inc;
    logic             used_dec;
    logic             ov_inc;
    logic             ov_dec;
    logic             moved_inc;
    logic             set_status;
    status_e          status_val;
    logic             ld_out;
  } ctrl_t;

endpackage : dstq_pkg

`default_nettype wire

// File: rtl/dstq_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for the request and response transactions.
// Depends on dstq_pkg for the payload types.

interface dstq_req_if import dstq_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface : dstq_req_if

interface dstq_rsp_if import dstq_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface : dstq_rsp_if

`default_nettype wire

// File: rtl/deadline_sorted_task_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the earliest-deadline-first task queue.
// Depends on dstq_pkg and on the channel interfaces in dstq_if.sv.
//
// Usage: each request transaction on req_i carries one command (insert, remove by id,
// cleanup of overdue tasks, or trim of the oldest overdue entry). Every command gives
// exactly one response transaction on rsp_o with status, counts and the head task.
// The active table is a row of registers kept sorted by deadline; one shared magnitude
// comparator walks it one entry a cycle under a small sequencer.
// Steps from the request transaction to the response: insert scans the table up to its
// rank, then passes update and done, and a refused insert goes from search to done;
// remove scans up to the matching entry, then update and done, or the whole active
// count when the id is absent; cleanup moves one overdue head per clean step; trim
// passes trim and done. One command is worked at a time; req_i.ready is high only
// between commands.
// The response sits in an output register, so the next request is accepted while it
// waits; if the receiver stalls, a finished second command holds until the register frees.
// Reset empties the active table and the overdue queue and drops any pending response.
// Only the overdue count is visible at the ports, so the overdue queue keeps its count.

module deadline_sorted_task_queue import dstq_pkg::*; (
  input  wire      clk_i,
  input  wire      rst_ni,
  dstq_req_if.sink   req_i,
  dstq_rsp_if.source rsp_o
);

  // State and datapath registers.
  state_e                state_q, state_d;
  ctrl_t                 ctrl;
  cmd_e                  cmd_q;
  logic [ID_BITS-1:0]    id_q;
  logic [TIME_BITS-1:0]  dl_q;
  logic [TIME_BITS-1:0]  now_q;
  logic [CNT_W-1:0]      idx_q;
  logic [IDX_W-1:0]      pos_q;
  logic [IDX_W-1:0]      res_pos_q;
  logic [CNT_W-1:0]      moved_q;
  status_e               status_q;
  logic [CNT_W-1:0]      used_q;
  logic [OV_W-1:0]       ov_q;
  logic [TIME_BITS-1:0]  ent_dl_q [ACTIVE_DEPTH];
  logic [ID_BITS-1:0]    ent_id_q [ACTIVE_DEPTH];
  logic                  out_valid_q;
  rsp_t                  out_q;

  // Shared comparator and scan helpers.
  logic [TIME_BITS-1:0]  cmp_a, cmp_b;
  logic                  cmp_lt;
  logic [IDX_W-1:0]      rd_idx;
  logic                  in_range;
  logic                  id_hit;
  logic                  table_full;
  logic                  ov_full;
  logic [IDX_W-1:0]      del_pos;
  logic                  req_fire;
  rsp_t                  rsp_d;

  assign req_fire   = req_i.valid && req_i.ready;
  assign rd_idx     = idx_q[IDX_W-1:0];
  assign in_range   = idx_q < used_q;
  assign id_hit     = ent_id_q[rd_idx] == id_q;
  assign table_full = used_q == CNT_W'(ACTIVE_DEPTH);
  assign ov_full    = ov_q == OV_W'(OVERDUE_DEPTH);
  assign del_pos    = ctrl.del_head ? '0 : pos_q;

  // The one magnitude comparator: insert asks whether the new deadline is earlier than
  // the scanned entry, cleanup asks whether the head deadline is earlier than now.
  always_comb begin
    if (state_q == S_CLEAN) begin
      cmp_a = ent_dl_q[0];
      cmp_b = now_q;
    end else begin
      cmp_a = dl_q;
      cmp_b = ent_dl_q[rd_idx];
    end
  end
  assign cmp_lt = cmp_a < cmp_b;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          case (req_i.payload.cmd)
            CMD_INSERT:  state_d = S_SEARCH;
            CMD_REMOVE:  state_d = S_SEARCH;
            CMD_CLEANUP: state_d = S_CLEAN;
            CMD_TRIM:    state_d = S_TRIM;
            default:     state_d = S_TRIM;
          endcase
        end
      end
      S_SEARCH: begin
        if (cmd_q == CMD_INSERT) begin
          if (table_full) begin
            state_d = S_DONE;
          end else if (!in_range || cmp_lt) begin
            state_d = S_UPDATE;
          end
        end else begin
          if (!in_range) begin
            state_d = S_DONE;
          end else if (id_hit) begin
            state_d = S_UPDATE;
          end
        end
      end
      S_UPDATE: state_d = S_DONE;
      S_CLEAN: begin
        if (!(used_q != '0 && cmp_lt)) begin
          state_d = S_DONE;
        end
      end
      S_TRIM: state_d = S_DONE;
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    ctrl            = '0;
    ctrl.status_val = STAT_OK;
    case (state_q)
      S_IDLE: begin
        ctrl.ld_req = req_fire;
      end
      S_SEARCH: begin
        if (cmd_q == CMD_INSERT) begin
          if (table_full) begin
            ctrl.set_status = 1'b1;
            ctrl.status_val = STAT_FULL;
          end else if (!in_range || cmp_lt) begin
            ctrl.set_pos = 1'b1;
          end else begin
            ctrl.idx_inc = 1'b1;
          end
        end else begin
          if (!in_range) begin
            ctrl.set_status = 1'b1;
            ctrl.status_val = (used_q == '0) ? STAT_EMPTY : STAT_NOT_FOUND;
          end else if (id_hit) begin
            ctrl.set_pos = 1'b1;
          end else begin
            ctrl.idx_inc = 1'b1;
          end
        end
      end
      S_UPDATE: begin
        if (cmd_q == CMD_INSERT) begin
          ctrl.wr_ins   = 1'b1;
          ctrl.used_inc = 1'b1;
        end else begin
          ctrl.wr_del   = 1'b1;
          ctrl.used_dec = 1'b1;
        end
      end
      S_CLEAN: begin
        if (used_q != '0 && cmp_lt) begin
          ctrl.wr_del    = 1'b1;
          ctrl.del_head  = 1'b1;
          ctrl.used_dec  = 1'b1;
          ctrl.moved_inc = 1'b1;
          if (ov_full) begin
            ctrl.set_status = 1'b1;
            ctrl.status_val = STAT_DROPPED;
          end else begin
            ctrl.ov_inc = 1'b1;
          end
        end
      end
      S_TRIM: begin
        if (ov_q == '0) begin
          ctrl.set_status = 1'b1;
          ctrl.status_val = STAT_EMPTY;
        end else begin
          ctrl.ov_dec = 1'b1;
        end
      end
      S_DONE: begin
        ctrl.ld_out = !out_valid_q || rsp_o.ready;
      end
      default: ctrl = '0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      ov_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl.used_inc) begin
        used_q <= used_q + CNT_W'(1);
      end else if (ctrl.used_dec) begin
        used_q <= used_q - CNT_W'(1);
      end
      if (ctrl.ov_inc) begin
        ov_q <= ov_q + OV_W'(1);
      end else if (ctrl.ov_dec) begin
        ov_q <= ov_q - OV_W'(1);
      end
      if (ctrl.ld_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Per-command working registers.
  always_ff @(posedge clk_i) begin
    if (ctrl.ld_req) begin
      cmd_q     <= req_i.payload.cmd;
      id_q      <= req_i.payload.task_id;
      dl_q      <= req_i.payload.deadline;
      now_q     <= req_i.payload.now;
      idx_q     <= '0;
      moved_q   <= '0;
      res_pos_q <= '0;
      status_q  <= STAT_OK;
    end else begin
      if (ctrl.idx_inc) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (ctrl.moved_inc) begin
        moved_q <= moved_q + CNT_W'(1);
      end
      if (ctrl.set_status) begin
        status_q <= ctrl.status_val;
      end
      if (ctrl.wr_ins) begin
        res_pos_q <= pos_q;
      end
    end
    if (ctrl.set_pos) begin
      pos_q <= rd_idx;
    end
  end

  // Active table: one shift of the whole row opens or closes a slot.
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < ACTIVE_DEPTH; j++) begin
      if (ctrl.wr_ins) begin
        if (IDX_W'(j) == pos_q) begin
          ent_dl_q[j] <= dl_q;
          ent_id_q[j] <= id_q;
        end else if (j > 0 && IDX_W'(j) > pos_q) begin
          ent_dl_q[j] <= ent_dl_q[(j > 0) ? j - 1 : 0];
          ent_id_q[j] <= ent_id_q[(j > 0) ? j - 1 : 0];
        end
      end else if (ctrl.wr_del) begin
        if (j < ACTIVE_DEPTH - 1 && IDX_W'(j) >= del_pos) begin
          ent_dl_q[j] <= ent_dl_q[(j < ACTIVE_DEPTH - 1) ? j + 1 : j];
          ent_id_q[j] <= ent_id_q[(j < ACTIVE_DEPTH - 1) ? j + 1 : j];
        end
      end
    end
  end

  // Response assembly from the state after the command.
  always_comb begin
    rsp_d.status        = status_q;
    rsp_d.position      = res_pos_q;
    rsp_d.active_count  = used_q;
    rsp_d.overdue_count = ov_q;
    rsp_d.moved_count   = moved_q;
    if (used_q != '0) begin
      rsp_d.head_id       = ent_id_q[0];
      rsp_d.head_deadline = ent_dl_q[0];
    end else begin
      rsp_d.head_id       = '0;
      rsp_d.head_deadline = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (ctrl.ld_out) begin
      out_q <= rsp_d;
    end
  end

  assign req_i.ready   = state_q == S_IDLE;
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

endmodule : deadline_sorted_task_queue

`default_nettype wire
